[rtl/signed_integer_to_base_digits_assert.svh]
// Assertion macros for the signed integer to base digits block.
`ifndef SIGNED_INTEGER_TO_BASE_DIGITS_ASSERT_SVH
`define SIGNED_INTEGER_TO_BASE_DIGITS_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define SIBD_ASSERT_HOLDS(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define SIBD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/sibd_pkg.sv]
// Shared constants, types and helper functions for the base digits converter.
package sibd_pkg;

    localparam int DATA_W        = 32;   // input number width
    localparam int STEP_W        = 5;    // counts the 32 division steps
    localparam int CHAR_W        = 8;
    localparam int NUM_CHARS     = 16;
    localparam int CHAR_IDX_W    = 4;
    localparam int CHARS_W       = NUM_CHARS * CHAR_W;
    localparam int MAX_DIGITS    = 32;   // radix 2 of 2^31
    localparam int CNT_W         = 6;    // holds 0..MAX_DIGITS
    localparam int SIZE_W        = 5;
    localparam int DEF_MAX_RADIX = 16;
    localparam int APB_ADDR_W    = 5;
    localparam int APB_DATA_W    = 64;
    localparam int REG_IDX_W     = 2;

    localparam logic [REG_IDX_W-1:0] REG_ALPHABET_SIZE    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_DIGIT_CHARS_LOW  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_DIGIT_CHARS_HIGH = 2'd2;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

    // alphabet scan status
    typedef struct packed {
        logic busy;
        logic ok;
    } chk_stat_t;

    // divider control
    typedef struct packed {
        logic              load;
        logic [DATA_W-1:0] mag;
    } div_ctrl_t;

    // divider status
    typedef struct packed {
        logic done;   // digit ready this cycle
        logic last;   // quotient reached zero
    } div_stat_t;

    function automatic logic is_bad_char(input logic [CHAR_W-1:0] c);
        return (c == CH_NUL) || (c == CH_PLUS) || (c == CH_MINUS) ||
               (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic [CHAR_W-1:0] char_at(input logic [CHARS_W-1:0]    chars,
                                                  input logic [CHAR_IDX_W-1:0] idx);
        return chars[{idx, 3'b000} +: CHAR_W];
    endfunction

endpackage

[rtl/sibd_chk.sv]
// Alphabet scan: checks one character per cycle against the forbidden set and the rest.
module sibd_chk import sibd_pkg::*; #(
    parameter int MAX_RADIX = DEF_MAX_RADIX
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [SIZE_W-1:0]  size,
    input  logic [CHARS_W-1:0] chars,
    output chk_stat_t          stat
);

    localparam int IW = $clog2(MAX_RADIX);

    logic          busy_reg;
    logic          ok_reg;
    logic          bad_reg;
    logic          bad_next;
    logic [IW-1:0] idx_reg;

    logic [CHAR_W-1:0] c_cur;
    logic              in_use;
    logic              dup;
    logic              last_step;
    logic              size_ok;

    always_comb begin
        c_cur  = char_at(chars, CHAR_IDX_W'(idx_reg));
        in_use = SIZE_W'(idx_reg) < size;
        dup    = 1'b0;
        // compare against every later character in use
        for (int j = 0; j < MAX_RADIX; j++) begin
            if ((SIZE_W'(j) > SIZE_W'(idx_reg)) && (SIZE_W'(j) < size) &&
                (char_at(chars, CHAR_IDX_W'(j)) == c_cur)) begin
                dup = 1'b1;
            end
        end
        bad_next  = bad_reg | (in_use & (is_bad_char(c_cur) | dup));
        last_step = idx_reg == IW'(MAX_RADIX - 1);
        size_ok   = (size >= SIZE_W'(2)) && (size <= SIZE_W'(MAX_RADIX));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            ok_reg   <= 1'b0;
            bad_reg  <= 1'b0;
            idx_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            ok_reg   <= 1'b0;
            bad_reg  <= 1'b0;
            idx_reg  <= '0;
        end else if (busy_reg) begin
            bad_reg <= bad_next;
            idx_reg <= idx_reg + 1'b1;
            if (last_step) begin
                busy_reg <= 1'b0;
                ok_reg   <= size_ok & ~bad_next;
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.ok   = ok_reg;

endmodule

[rtl/sibd_div.sv]
// Bit-serial restoring divider: one quotient bit per cycle, repeats on the quotient.
module sibd_div import sibd_pkg::*; #(
    parameter int MAX_RADIX = DEF_MAX_RADIX
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  div_ctrl_t                      ctrl,
    input  logic [$clog2(MAX_RADIX):0]     radix,
    output div_stat_t                      stat,
    output logic [$clog2(MAX_RADIX)-1:0]   digit
);

    localparam int DW = $clog2(MAX_RADIX);

    logic              run_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DATA_W-1:0] mag_reg;
    logic [DATA_W-1:0] mag_next;
    logic [DW-1:0]     rem_reg;
    logic [DW-1:0]     rem_next;

    logic [DW:0] trial;
    logic        qbit;
    logic        last_step;
    logic        quot_zero;

    always_comb begin
        trial     = {rem_reg, mag_reg[DATA_W-1]};
        qbit      = trial >= radix;
        rem_next  = qbit ? DW'(trial - radix) : DW'(trial);
        mag_next  = {mag_reg[DATA_W-2:0], qbit};
        last_step = step_reg == STEP_W'(DATA_W - 1);
        quot_zero = mag_next == '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            step_reg <= '0;
        end else if (ctrl.load) begin
            run_reg  <= 1'b1;
            step_reg <= '0;
        end else if (run_reg) begin
            step_reg <= step_reg + 1'b1;
            if (last_step && quot_zero) begin
                run_reg <= 1'b0;
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            mag_reg <= ctrl.mag;
            rem_reg <= '0;
        end else if (run_reg) begin
            mag_reg <= mag_next;
            rem_reg <= last_step ? '0 : rem_next;
        end
    end

    assign stat.done = run_reg & last_step;
    assign stat.last = quot_zero;
    assign digit     = rem_next;

endmodule

[rtl/signed_integer_to_base_digits.sv]
// Top level: signed 32-bit number to text in a configured radix and alphabet.
//
//  channel   dir  handshake          payload
//  s_        in   s_tvalid/s_tready  s_tdata[31:0] = number
//  m_        out  m_tvalid/m_tready  m_tdata[7:0] = char_out, m_tlast = last_char
//  apb       in   psel/penable       regs at 0x00 size, 0x08 chars 0-7, 0x10 chars 8-15
//
// A number with D digits is converted by the bit-serial divider, which makes one quotient
// bit per cycle; then D characters, plus one for '-', leave at one per cycle while m_tready
// is high. The next number is taken once the last character sits in m_ output.
// aresetn (sync, low) clears control and the registers. Every register write starts
// an alphabet scan; s_tready stays low until it ends.
// m_tready low while m_tvalid is high holds the output register and stops popping the digit stack.
`include "signed_integer_to_base_digits_assert.svh"

module signed_integer_to_base_digits import sibd_pkg::*; #(
    parameter int MAX_RADIX = DEF_MAX_RADIX
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [DATA_W-1:0]     s_tdata,   // [31:0] number
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [CHAR_W-1:0]     m_tdata,   // [7:0] char_out
    output logic                  m_tlast,   // last_char
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int DW = $clog2(MAX_RADIX);

    typedef enum logic [2:0] {
        ST_IDLE    = 3'b001,
        ST_CONVERT = 3'b010,
        ST_EMIT    = 3'b100
    } state_t;

    // ---------------- configuration registers ----------------
    logic                  cfg_wr;
    logic [REG_IDX_W-1:0]  reg_idx;
    logic [SIZE_W-1:0]     size_reg;
    logic [APB_DATA_W-1:0] chars_lo_reg;
    logic [APB_DATA_W-1:0] chars_hi_reg;
    logic [CHARS_W-1:0]    chars;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign reg_idx = paddr[APB_ADDR_W-1:3];   // 8-byte register stride
    assign chars   = {chars_hi_reg, chars_lo_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg     <= '0;
            chars_lo_reg <= '0;
            chars_hi_reg <= '0;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_ALPHABET_SIZE:    size_reg     <= pwdata[SIZE_W-1:0];
                REG_DIGIT_CHARS_LOW:  chars_lo_reg <= pwdata;
                REG_DIGIT_CHARS_HIGH: chars_hi_reg <= pwdata;
                default: ;                       // unmapped, ignored
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_ALPHABET_SIZE:    prdata = APB_DATA_W'(size_reg);
            REG_DIGIT_CHARS_LOW:  prdata = chars_lo_reg;
            REG_DIGIT_CHARS_HIGH: prdata = chars_hi_reg;
            default:              prdata = '0;
        endcase
    end

    // ---------------- alphabet scan ----------------
    chk_stat_t chk_stat;

    sibd_chk #(
        .MAX_RADIX (MAX_RADIX)
    ) u_chk (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cfg_wr),
        .size    (size_reg),
        .chars   (chars),
        .stat    (chk_stat)
    );

    // ---------------- divider ----------------
    div_ctrl_t     div_ctrl;
    div_stat_t     div_stat;
    logic [DW-1:0] div_digit;
    logic          s_accept;
    logic          in_neg;

    assign s_accept      = s_tvalid & s_tready;
    assign in_neg        = s_tdata[DATA_W-1];
    assign div_ctrl.load = s_accept & chk_stat.ok;
    // two's complement negate; the most negative number maps to 2^31 unsigned
    assign div_ctrl.mag  = in_neg ? (~s_tdata + 1'b1) : s_tdata;

    sibd_div #(
        .MAX_RADIX (MAX_RADIX)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (div_ctrl),
        .radix   (size_reg[DW:0]),    // valid alphabets never exceed MAX_RADIX
        .stat    (div_stat),
        .digit   (div_digit)
    );

    // ---------------- sequencer, digit stack, output register ----------------
    state_t            state_reg, state_next;
    logic              neg_reg, neg_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DW-1:0]     stack_reg [MAX_DIGITS];
    logic              push, pop;
    logic              out_free;
    logic              out_load;
    logic [CHAR_W-1:0] out_char_next;
    logic              out_last_next;
    logic              m_tvalid_reg;
    logic [CHAR_W-1:0] m_tdata_reg;
    logic              m_tlast_reg;

    assign s_tready = (state_reg == ST_IDLE) & ~chk_stat.busy & ~cfg_wr;
    assign out_free = ~m_tvalid_reg | m_tready;

    always_comb begin
        state_next    = state_reg;
        neg_next      = neg_reg;
        cnt_next      = cnt_reg;
        push          = 1'b0;
        pop           = 1'b0;
        out_load      = 1'b0;
        out_char_next = m_tdata_reg;
        out_last_next = m_tlast_reg;
        case (state_reg)
            ST_IDLE: begin
                // an item taken with a bad alphabet gives nothing
                if (div_ctrl.load) begin
                    neg_next   = in_neg;
                    cnt_next   = '0;
                    state_next = ST_CONVERT;
                end
            end
            ST_CONVERT: begin
                // digits arrive least significant first
                if (div_stat.done) begin
                    push     = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    if (div_stat.last) begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (neg_reg) begin
                        out_char_next = CH_MINUS;
                        out_last_next = 1'b0;
                        neg_next      = 1'b0;
                    end else begin
                        out_char_next = char_at(chars, CHAR_IDX_W'(stack_reg[0]));
                        out_last_next = cnt_reg == CNT_W'(1);
                        pop           = 1'b1;
                        cnt_next      = cnt_reg - 1'b1;
                        if (cnt_reg == CNT_W'(1)) begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            neg_reg      <= 1'b0;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            neg_reg   <= neg_next;
            cnt_reg   <= cnt_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // stack: last pushed (most significant) digit sits at entry 0
    always_ff @(posedge aclk) begin
        if (push) begin
            stack_reg[0] <= div_digit;
            for (int i = 1; i < MAX_DIGITS; i++) begin
                stack_reg[i] <= stack_reg[i-1];
            end
        end else if (pop) begin
            for (int i = 0; i < MAX_DIGITS - 1; i++) begin
                stack_reg[i] <= stack_reg[i+1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= out_char_next;
            m_tlast_reg <= out_last_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // ---------------- assertions ----------------
    `SIBD_ASSERT_HOLDS(a_div_done_in_convert, div_stat.done, state_reg == ST_CONVERT, "divider digit outside conversion")
    `SIBD_ASSERT_HOLDS(a_emit_has_digits, state_reg == ST_EMIT, cnt_reg != '0, "emit with empty digit stack")
    `SIBD_ASSERT_HOLDS(a_out_from_emit, $rose(m_tvalid_reg), $past(state_reg == ST_EMIT), "result transfer not from emit")
    `SIBD_ASSERT_NEXT(a_last_ends_item, out_load && out_last_next, state_reg == ST_IDLE, "last character did not end the item")

endmodule
